@@ design/qrs_pkg.sv @@
`default_nettype none
package qrs_pkg;

    // field widths
    localparam int COEF_W        = 32;
    localparam int TOL_W         = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PROD_W        = 2 * COEF_W;
    localparam int DISC_W        = PROD_W + 2;
    localparam int SQRT_W        = DISC_W / 2;
    localparam int QUO_W         = COEF_W;

    // root class codes
    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_TWO  = 2'd2,
        CLS_ALL  = 2'd3
    } root_class_t;

    // which divisions an item needs
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LIN,
        KIND_DBL,
        KIND_TWO
    } div_kind_t;

    // per-item context carried down the pipeline
    typedef struct packed {
        root_class_t               cls;
        div_kind_t                 kind;
        logic signed [COEF_W-1:0]  a;
        logic signed [COEF_W-1:0]  b;
        logic signed [COEF_W-1:0]  c;
    } qrs_ctx_t;

endpackage
`default_nettype wire

@@ design/qrs_front.sv @@
`default_nettype none
module qrs_front #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [qrs_pkg::COEF_W-1:0]  coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0]  coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0]  coef_c,
    input  logic        [qrs_pkg::TOL_W-1:0]   tol,
    output logic                               valid,
    output qrs_pkg::qrs_ctx_t                  ctx,
    output logic        [qrs_pkg::DISC_W-1:0]  disc
);
    import qrs_pkg::*;

    logic                     s1_valid_reg;
    logic signed [COEF_W-1:0] s1_a_reg, s1_b_reg, s1_c_reg;
    logic [COEF_W-1:0]        s1_ma_reg, s1_mb_reg, s1_mc_reg;
    logic                     s1_az_reg, s1_bz_reg, s1_cz_reg;
    logic [COEF_W-1:0]        ma_next, mb_next, mc_next;

    logic                     s2_valid_reg;
    logic signed [COEF_W-1:0] s2_a_reg, s2_b_reg, s2_c_reg;
    logic                     s2_az_reg, s2_bz_reg, s2_cz_reg, s2_sdiff_reg;
    logic [PROD_W-1:0]        s2_bb_reg, s2_ac_reg;

    logic                     s3_valid_reg;
    logic signed [COEF_W-1:0] s3_a_reg, s3_b_reg, s3_c_reg;
    logic                     s3_az_reg, s3_bz_reg, s3_cz_reg, s3_neg_reg;
    logic [DISC_W-1:0]        s3_disc_reg;
    logic [DISC_W-1:0]        bb_w, ac4_w, sum_w, dif_m, disc_next;
    logic [DISC_W:0]          dif_p;
    logic                     neg_next;

    logic                     s4_valid_reg;
    qrs_ctx_t                 s4_ctx_reg;
    logic [DISC_W-1:0]        s4_disc_reg;
    qrs_ctx_t                 ctx_next;
    logic [DISC_W-1:0]        tw;

    // magnitudes of the coefficients
    assign ma_next = coef_a[COEF_W-1] ? COEF_W'(-coef_a) : COEF_W'(coef_a);
    assign mb_next = coef_b[COEF_W-1] ? COEF_W'(-coef_b) : COEF_W'(coef_b);
    assign mc_next = coef_c[COEF_W-1] ? COEF_W'(-coef_c) : COEF_W'(coef_c);

    // stage 1: register beat, magnitudes and zero tests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg  <= coef_a;
            s1_b_reg  <= coef_b;
            s1_c_reg  <= coef_c;
            s1_ma_reg <= ma_next;
            s1_mb_reg <= mb_next;
            s1_mc_reg <= mc_next;
            s1_az_reg <= ma_next <= COEF_W'(tol);
            s1_bz_reg <= mb_next <= COEF_W'(tol);
            s1_cz_reg <= mc_next <= COEF_W'(tol);
        end
    end

    // stage 2: products b*b and a*c
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_a_reg     <= s1_a_reg;
            s2_b_reg     <= s1_b_reg;
            s2_c_reg     <= s1_c_reg;
            s2_az_reg    <= s1_az_reg;
            s2_bz_reg    <= s1_bz_reg;
            s2_cz_reg    <= s1_cz_reg;
            s2_sdiff_reg <= s1_a_reg[COEF_W-1] != s1_c_reg[COEF_W-1];
            s2_bb_reg    <= s1_mb_reg * s1_mb_reg;
            s2_ac_reg    <= s1_ma_reg * s1_mc_reg;
        end
    end

    // stage 3: discriminant magnitude and sign
    assign bb_w  = DISC_W'(s2_bb_reg);
    assign ac4_w = {s2_ac_reg, 2'b00};
    assign sum_w = bb_w + ac4_w;
    assign dif_p = {1'b0, bb_w} - {1'b0, ac4_w};
    assign dif_m = ac4_w - bb_w;

    always_comb
    begin
        if (s2_sdiff_reg)
        begin
            neg_next  = 1'b0;
            disc_next = sum_w;
        end
        else
        begin
            neg_next  = dif_p[DISC_W];
            disc_next = dif_p[DISC_W] ? dif_m : dif_p[DISC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_a_reg    <= s2_a_reg;
            s3_b_reg    <= s2_b_reg;
            s3_c_reg    <= s2_c_reg;
            s3_az_reg   <= s2_az_reg;
            s3_bz_reg   <= s2_bz_reg;
            s3_cz_reg   <= s2_cz_reg;
            s3_neg_reg  <= neg_next;
            s3_disc_reg <= disc_next;
        end
    end

    // stage 4: classify
    assign tw = DISC_W'(tol) << FRAC_BITS;

    always_comb
    begin
        ctx_next.a = s3_a_reg;
        ctx_next.b = s3_b_reg;
        ctx_next.c = s3_c_reg;
        if (s3_az_reg)
        begin
            if (s3_bz_reg)
            begin
                ctx_next.cls  = s3_cz_reg ? CLS_ALL : CLS_NONE;
                ctx_next.kind = KIND_NONE;
            end
            else
            begin
                ctx_next.cls  = CLS_ONE;
                ctx_next.kind = KIND_LIN;
            end
        end
        else if (s3_neg_reg)
        begin
            ctx_next.cls  = CLS_NONE;
            ctx_next.kind = KIND_NONE;
        end
        else if (s3_disc_reg <= tw)
        begin
            ctx_next.cls  = CLS_ONE;
            ctx_next.kind = KIND_DBL;
        end
        else
        begin
            ctx_next.cls  = CLS_TWO;
            ctx_next.kind = KIND_TWO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_ctx_reg  <= ctx_next;
            s4_disc_reg <= s3_disc_reg;
        end
    end

    assign valid = s4_valid_reg;
    assign ctx   = s4_ctx_reg;
    assign disc  = s4_disc_reg;

endmodule
`default_nettype wire

@@ design/qrs_sqrt.sv @@
`default_nettype none
module qrs_sqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  qrs_pkg::qrs_ctx_t                 in_ctx,
    input  logic [qrs_pkg::DISC_W-1:0]        disc,
    output logic                              valid,
    output qrs_pkg::qrs_ctx_t                 ctx,
    output logic [qrs_pkg::SQRT_W-1:0]        root
);
    import qrs_pkg::*;

    localparam int STEPS = SQRT_W;
    localparam int TW    = DISC_W + 2;

    logic              valid_reg [STEPS];
    qrs_ctx_t          ctx_reg   [STEPS];
    logic [DISC_W-1:0] rem_reg   [STEPS];
    logic [SQRT_W-1:0] root_reg  [STEPS];

    // one root bit per stage, most significant first
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int BIT = STEPS - 1 - k;

        logic              v_in;
        qrs_ctx_t          c_in;
        logic [DISC_W-1:0] rem_in;
        logic [SQRT_W-1:0] root_in;
        logic [TW-1:0]     trial;
        logic              take;
        logic [DISC_W-1:0] rem_next;
        logic [SQRT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign c_in    = in_ctx;
            assign rem_in  = disc;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[k-1];
            assign c_in    = ctx_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
        assign trial     = (TW'(root_in) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        assign take      = TW'(rem_in) >= trial;
        assign rem_next  = take ? DISC_W'(TW'(rem_in) - trial) : rem_in;
        assign root_next = take ? (root_in | (SQRT_W'(1) << BIT)) : root_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[k]  <= c_in;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign valid = valid_reg[STEPS-1];
    assign ctx   = ctx_reg[STEPS-1];
    assign root  = root_reg[STEPS-1];

endmodule
`default_nettype wire

@@ design/qrs_div.sv @@
`default_nettype none
module qrs_div #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  qrs_pkg::qrs_ctx_t                    ctx,
    input  logic [qrs_pkg::SQRT_W-1:0]           root,
    output logic                                 valid,
    output qrs_pkg::root_class_t                 cls,
    output qrs_pkg::div_kind_t                   kind,
    output logic [1:0][qrs_pkg::QUO_W-1:0]       quo,
    output logic [1:0]                           big,
    output logic [1:0]                           neg
);
    import qrs_pkg::*;

    localparam int LANES = 2;
    localparam int VW    = SQRT_W + 2;
    localparam int MW    = VW - 1;
    localparam int DW    = COEF_W + 1;
    localparam int NW    = MW + FRAC_BITS + 2;
    localparam int STEPS = QUO_W;
    localparam int W     = NW + QUO_W;

    // stage p1: numerator and divisor magnitudes, quotient sign
    logic signed [VW-1:0]         sx, bx, p0, n0, p1, n1;
    logic [COEF_W-1:0]            mag_a, mag_b, mag_c;
    logic [LANES-1:0][MW-1:0]     nmag_next;
    logic [LANES-1:0][DW-1:0]     dmag_next;
    logic [LANES-1:0]             neg_next;
    logic                         c_pos, b_pos;

    logic                         p1_valid_reg;
    root_class_t                  p1_cls_reg;
    div_kind_t                    p1_kind_reg;
    logic [LANES-1:0][MW-1:0]     p1_nmag_reg;
    logic [LANES-1:0][DW-1:0]     p1_dmag_reg;
    logic [LANES-1:0]             p1_neg_reg;

    logic [LANES-1:0][NW-1:0]     num_next;

    logic                         p2_valid_reg;
    root_class_t                  p2_cls_reg;
    div_kind_t                    p2_kind_reg;
    logic [LANES-1:0][NW-1:0]     p2_num_reg;
    logic [LANES-1:0][DW:0]       p2_den_reg;
    logic [LANES-1:0]             p2_neg_reg;

    logic [LANES-1:0]             big_next;

    logic                         p3_valid_reg;
    root_class_t                  p3_cls_reg;
    div_kind_t                    p3_kind_reg;
    logic [LANES-1:0][NW-1:0]     p3_num_reg;
    logic [LANES-1:0][DW:0]       p3_den_reg;
    logic [LANES-1:0]             p3_neg_reg;
    logic [LANES-1:0]             p3_big_reg;

    logic                         st_valid_reg [STEPS];
    root_class_t                  st_cls_reg   [STEPS];
    div_kind_t                    st_kind_reg  [STEPS];
    logic [LANES-1:0][NW-1:0]     st_rem_reg   [STEPS];
    logic [LANES-1:0][DW:0]       st_den_reg   [STEPS];
    logic [LANES-1:0][QUO_W-1:0]  st_quo_reg   [STEPS];
    logic [LANES-1:0]             st_big_reg   [STEPS];
    logic [LANES-1:0]             st_neg_reg   [STEPS];

    assign sx    = $signed({2'b00, root});
    assign bx    = VW'(ctx.b);
    assign p0    = sx - bx;
    assign n0    = bx - sx;
    assign p1    = sx + bx;
    assign n1    = -sx - bx;
    assign mag_a = ctx.a[COEF_W-1] ? COEF_W'(-ctx.a) : COEF_W'(ctx.a);
    assign mag_b = ctx.b[COEF_W-1] ? COEF_W'(-ctx.b) : COEF_W'(ctx.b);
    assign mag_c = ctx.c[COEF_W-1] ? COEF_W'(-ctx.c) : COEF_W'(ctx.c);
    assign c_pos = !ctx.c[COEF_W-1] && (ctx.c != '0);
    assign b_pos = !ctx.b[COEF_W-1] && (ctx.b != '0);

    always_comb
    begin
        // second lane only serves the two-root case: (-b - s) / 2a
        nmag_next[1] = n1[VW-1] ? MW'(p1) : MW'(n1);
        dmag_next[1] = {mag_a, 1'b0};
        neg_next[1]  = n1[VW-1] != ctx.a[COEF_W-1];
        case (ctx.kind)
            KIND_LIN:
            begin
                nmag_next[0] = MW'(mag_c);
                dmag_next[0] = DW'(mag_b);
                neg_next[0]  = c_pos != ctx.b[COEF_W-1];
            end
            KIND_DBL:
            begin
                nmag_next[0] = MW'(mag_b);
                dmag_next[0] = {mag_a, 1'b0};
                neg_next[0]  = b_pos != ctx.a[COEF_W-1];
            end
            default:
            begin
                nmag_next[0] = p0[VW-1] ? MW'(n0) : MW'(p0);
                dmag_next[0] = {mag_a, 1'b0};
                neg_next[0]  = p0[VW-1] != ctx.a[COEF_W-1];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_cls_reg  <= ctx.cls;
            p1_kind_reg <= ctx.kind;
            p1_nmag_reg <= nmag_next;
            p1_dmag_reg <= dmag_next;
            p1_neg_reg  <= neg_next;
        end
    end

    // stage p2: rounding numerator 2*n*2^F + d over divisor 2*d
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            num_next[l] = NW'({p1_nmag_reg[l], {(FRAC_BITS + 1){1'b0}}})
                        + NW'(p1_dmag_reg[l]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_cls_reg  <= p1_cls_reg;
            p2_kind_reg <= p1_kind_reg;
            p2_num_reg  <= num_next;
            for (int l = 0; l < LANES; l++)
                p2_den_reg[l] <= {p1_dmag_reg[l], 1'b0};
            p2_neg_reg  <= p1_neg_reg;
        end
    end

    // stage p3: quotient too large for the result width
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            big_next[l] = W'(p2_num_reg[l]) >= (W'(p2_den_reg[l]) << QUO_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (en)
            p3_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_cls_reg  <= p2_cls_reg;
            p3_kind_reg <= p2_kind_reg;
            p3_num_reg  <= p2_num_reg;
            p3_den_reg  <= p2_den_reg;
            p3_neg_reg  <= p2_neg_reg;
            p3_big_reg  <= big_next;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int BIT = STEPS - 1 - k;

        logic                         v_in;
        root_class_t                  cls_in;
        div_kind_t                    kind_in;
        logic [LANES-1:0][NW-1:0]     rem_in;
        logic [LANES-1:0][DW:0]       den_in;
        logic [LANES-1:0][QUO_W-1:0]  quo_in;
        logic [LANES-1:0]             big_in;
        logic [LANES-1:0]             neg_in;
        logic [LANES-1:0][NW-1:0]     rem_next;
        logic [LANES-1:0][QUO_W-1:0]  quo_next;

        if (k == 0)
        begin : g_first
            assign v_in    = p3_valid_reg;
            assign cls_in  = p3_cls_reg;
            assign kind_in = p3_kind_reg;
            assign rem_in  = p3_num_reg;
            assign den_in  = p3_den_reg;
            assign quo_in  = '0;
            assign big_in  = p3_big_reg;
            assign neg_in  = p3_neg_reg;
        end
        else
        begin : g_next
            assign v_in    = st_valid_reg[k-1];
            assign cls_in  = st_cls_reg[k-1];
            assign kind_in = st_kind_reg[k-1];
            assign rem_in  = st_rem_reg[k-1];
            assign den_in  = st_den_reg[k-1];
            assign quo_in  = st_quo_reg[k-1];
            assign big_in  = st_big_reg[k-1];
            assign neg_in  = st_neg_reg[k-1];
        end

        always_comb
        begin
            logic [W-1:0] trial;
            for (int l = 0; l < LANES; l++)
            begin
                trial = W'(den_in[l]) << BIT;
                if (W'(rem_in[l]) >= trial)
                begin
                    rem_next[l] = NW'(W'(rem_in[l]) - trial);
                    quo_next[l] = quo_in[l] | (QUO_W'(1) << BIT);
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                    quo_next[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_valid_reg[k] <= 1'b0;
            else if (en)
                st_valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_cls_reg[k]  <= cls_in;
                st_kind_reg[k] <= kind_in;
                st_rem_reg[k]  <= rem_next;
                st_den_reg[k]  <= den_in;
                st_quo_reg[k]  <= quo_next;
                st_big_reg[k]  <= big_in;
                st_neg_reg[k]  <= neg_in;
            end
        end
    end

    assign valid = st_valid_reg[STEPS-1];
    assign cls   = st_cls_reg[STEPS-1];
    assign kind  = st_kind_reg[STEPS-1];
    assign quo   = st_quo_reg[STEPS-1];
    assign big   = st_big_reg[STEPS-1];
    assign neg   = st_neg_reg[STEPS-1];

endmodule
`default_nettype wire

@@ design/quadratic_root_solver.sv @@
`default_nettype none
// channel   direction  handshake                 payload
// cfg       in         cfg_valid / cfg_ready     cfg_data (zero tolerance)
// in        in         in_valid / in_stall       coef_a, coef_b, coef_c
// out       out        out_valid / out_stall     root_class, first_root, second_root, overflow
//
// one beat in per cycle unless out_stall holds a pending result: 4 front stages (magnitudes,
// products, discriminant, classify), 33 square root stages (one root bit each), 3 divider
// setup stages, 32 divider stages (one quotient bit each) and the output register.
// reset clears all valid bits and sets the tolerance to 1.
// out_stall with a pending result freezes every stage; in_stall follows it.
module quadratic_root_solver #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic        [qrs_pkg::TOL_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [qrs_pkg::COEF_W-1:0]  coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0]  coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0]  coef_c,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic        [1:0]                  root_class,
    output logic signed [qrs_pkg::COEF_W-1:0]  first_root,
    output logic signed [qrs_pkg::COEF_W-1:0]  second_root,
    output logic                               overflow
);
    import qrs_pkg::*;

    localparam logic [QUO_W-1:0] POS_MAX = {1'b0, {(QUO_W - 1){1'b1}}};
    localparam logic [QUO_W-1:0] NEG_MAG = {1'b1, {(QUO_W - 1){1'b0}}};

    logic [TOL_W-1:0]             tol_reg;
    logic                         en;

    logic                         fr_valid;
    qrs_ctx_t                     fr_ctx;
    logic [DISC_W-1:0]            fr_disc;

    logic                         sq_valid;
    qrs_ctx_t                     sq_ctx;
    logic [SQRT_W-1:0]            sq_root;

    logic                         dv_valid;
    root_class_t                  dv_cls;
    div_kind_t                    dv_kind;
    logic [1:0][QUO_W-1:0]        dv_quo;
    logic [1:0]                   dv_big;
    logic [1:0]                   dv_neg;

    logic [1:0][QUO_W-1:0]        lane_val;
    logic [1:0]                   lane_ovf;
    logic [QUO_W-1:0]             first_next, second_next;
    logic                         ovf_next;

    logic                         out_valid_reg;
    root_class_t                  class_reg;
    logic [QUO_W-1:0]             first_reg, second_reg;
    logic                         ovf_reg;

    // whole pipeline advances unless a result is held
    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_W'(1);
        else if (cfg_valid)
            tol_reg <= cfg_data;
    end

    qrs_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .coef_a   (coef_a),
        .coef_b   (coef_b),
        .coef_c   (coef_c),
        .tol      (tol_reg),
        .valid    (fr_valid),
        .ctx      (fr_ctx),
        .disc     (fr_disc)
    );

    qrs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (fr_valid),
        .in_ctx   (fr_ctx),
        .disc     (fr_disc),
        .valid    (sq_valid),
        .ctx      (sq_ctx),
        .root     (sq_root)
    );

    qrs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .ctx      (sq_ctx),
        .root     (sq_root),
        .valid    (dv_valid),
        .cls      (dv_cls),
        .kind     (dv_kind),
        .quo      (dv_quo),
        .big      (dv_big),
        .neg      (dv_neg)
    );

    // sign and saturation per lane
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (!dv_neg[l])
            begin
                if (dv_big[l] || dv_quo[l][QUO_W-1])
                begin
                    lane_val[l] = POS_MAX;
                    lane_ovf[l] = 1'b1;
                end
                else
                begin
                    lane_val[l] = dv_quo[l];
                    lane_ovf[l] = 1'b0;
                end
            end
            else
            begin
                if (dv_big[l] || (dv_quo[l] > NEG_MAG))
                begin
                    lane_val[l] = NEG_MAG;
                    lane_ovf[l] = 1'b1;
                end
                else
                begin
                    lane_val[l] = -dv_quo[l];
                    lane_ovf[l] = 1'b0;
                end
            end
        end
    end

    // pick roots by case, unused roots are zero
    always_comb
    begin
        case (dv_kind)
            KIND_LIN:
            begin
                first_next  = lane_val[0];
                second_next = '0;
                ovf_next    = lane_ovf[0];
            end
            KIND_DBL:
            begin
                first_next  = lane_val[0];
                second_next = lane_val[0];
                ovf_next    = lane_ovf[0];
            end
            KIND_TWO:
            begin
                first_next  = lane_val[0];
                second_next = lane_val[1];
                ovf_next    = lane_ovf[0] | lane_ovf[1];
            end
            default:
            begin
                first_next  = '0;
                second_next = '0;
                ovf_next    = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            class_reg  <= dv_cls;
            first_reg  <= first_next;
            second_reg <= second_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign root_class  = class_reg;
    assign first_root  = $signed(first_reg);
    assign second_root = $signed(second_reg);
    assign overflow    = ovf_reg;

endmodule
`default_nettype wire
